// ----- rtl/core/lccu_pkg.sv -----
// Shared types and constants for the colored life cell update block.
// Holds the item and queue entry layouts and the rule constants.
// No dependencies.
package lccu_pkg;

   localparam int COLOR_BITS           = 24;
   localparam int NEIGHBORS            = 8;
   localparam int MASK_BITS            = NEIGHBORS + 1;
   localparam int LIVE_PICKS           = 3;
   localparam int CHANNELS             = 3;
   localparam int THRESHOLD_BITS       = 4;
   localparam int MODE_BITS            = 4;
   localparam int PICK_BITS            = 2;
   localparam int TALLY_BITS           = 4;
   localparam int QUEUE_DEPTH          = 4;
   localparam int CHANNEL_BITS_DEFAULT = 8;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 4'd8;
   localparam logic [TALLY_BITS-1:0]     SURVIVE_LOW     = 4'd2;
   localparam logic [TALLY_BITS-1:0]     BIRTH_TALLY     = 4'd3;
   localparam logic [PICK_BITS-1:0]      PICK_LAST       = 2'd2;
   localparam logic [PICK_BITS-1:0]      PICK_OVER       = 2'd3;

   typedef enum logic [1:0] {
      KIND_DEAD,
      KIND_COPY,
      KIND_MEAN
   } lccu_kind_type;

   typedef struct packed {
      logic [MASK_BITS-1:0]                  alive_mask;
      logic [COLOR_BITS-1:0]                 self_color;
      logic [NEIGHBORS-1:0][COLOR_BITS-1:0]  neighbor_color;
      logic [MODE_BITS-1:0]                  mode_draw;
      logic [PICK_BITS-1:0]                  pick_draw;
   } lccu_item_type;

   typedef struct packed {
      lccu_kind_type                         kind;
      logic [COLOR_BITS-1:0]                 color;
      logic [LIVE_PICKS-1:0][COLOR_BITS-1:0] live;
   } lccu_entry_type;

endpackage

// ----- rtl/core/lccu_front.sv -----
// Front end: holds the inherit threshold register and classifies each cell.
// Counts live neighbors, gathers the first three live colors, picks the outcome.
// Depends on lccu_pkg.
module lccu_front #(
   parameter int CHANNEL_BITS = lccu_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lccu_pkg::THRESHOLD_BITS-1:0]  csr_data,
   input  lccu_pkg::lccu_item_type              item,
   output lccu_pkg::lccu_entry_type             entry
);
   import lccu_pkg::*;

   localparam int CW = CHANNELS * CHANNEL_BITS;

   logic [THRESHOLD_BITS-1:0] threshold_ff;
   logic [THRESHOLD_BITS-1:0] threshold_in;
   logic [TALLY_BITS-1:0]     tally;
   logic [TALLY_BITS-1:0]     seen;
   logic [LIVE_PICKS-1:0][COLOR_BITS-1:0] live;
   logic [PICK_BITS-1:0]      pick_sat;
   logic                      self_alive;
   logic [CW+COLOR_BITS-1:0]  white_wide;
   logic [COLOR_BITS-1:0]     white;

   assign csr_ready    = 1'b1;
   assign threshold_in = csr_valid ? csr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // dead cells get every channel at full scale, cut to the color width
   assign white_wide = {{COLOR_BITS{1'b0}}, {CW{1'b1}}};
   assign white      = white_wide[COLOR_BITS-1:0];
   assign self_alive = item.alive_mask[NEIGHBORS];
   assign pick_sat   = (item.pick_draw == PICK_OVER) ? PICK_LAST : item.pick_draw;

   always_comb begin
      tally = '0;
      seen  = '0;
      live  = '0;
      for (int i = 0; i < NEIGHBORS; i++) begin
         if (item.alive_mask[i]) begin
            for (int j = 0; j < LIVE_PICKS; j++) begin
               if (seen == TALLY_BITS'(j)) begin
                  live[j] = item.neighbor_color[i];
               end
            end
            seen = seen + 1'b1;
         end
         tally = tally + {{(TALLY_BITS-1){1'b0}}, item.alive_mask[i]};
      end
   end

   always_comb begin
      entry.live = live;
      if (self_alive && (tally == SURVIVE_LOW || tally == BIRTH_TALLY)) begin
         entry.kind  = KIND_COPY;
         entry.color = item.self_color;
      end else if (!self_alive && tally == BIRTH_TALLY) begin
         if (item.mode_draw < threshold_ff) begin
            entry.kind  = KIND_COPY;
            entry.color = live[pick_sat];
         end else begin
            entry.kind  = KIND_MEAN;
            entry.color = '0;
         end
      end else begin
         entry.kind  = KIND_DEAD;
         entry.color = white;
      end
   end

endmodule

// ----- rtl/core/lccu_queue.sv -----
// Short FIFO of classified cells between the front end and the back end.
// Flip-flop slots; per cycle one write if not full, one read if not empty.
// Depends on lccu_pkg.
module lccu_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  lccu_pkg::lccu_entry_type  in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output lccu_pkg::lccu_entry_type  out_data
);
   import lccu_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   lccu_entry_type       slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff;
   logic [PTR_BITS-1:0]  wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff;
   logic [PTR_BITS-1:0]  rd_ptr_in;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [CNT_BITS-1:0]  cnt_in;
   logic                 push;
   logic                 pop;

   assign in_ready  = (cnt_ff != CNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // depth is a power of two, so the pointers wrap on their own
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not grow on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == CNT_BITS'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/core/lccu_back.sv -----
// Back end: squares and sums the live channels, then a bit-per-stage
// root pipeline finds the largest r with 3*r*r <= sum, and an output register.
// Depends on lccu_pkg.
module lccu_back #(
   parameter int CHANNEL_BITS = lccu_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  lccu_pkg::lccu_entry_type          q_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_alive,
   output logic [lccu_pkg::COLOR_BITS-1:0]   rsp_color
);
   import lccu_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam int CW = CHANNELS * CB;
   localparam int SQ = 2 * CB;
   localparam int SW = 2 * CB + 2;
   localparam logic [SW:0]   STEP_ONE = (SW+1)'(1);
   localparam logic [CB-1:0] ROOT_ONE = CB'(1);

   logic advance;

   // square stage
   logic                  sq_vld_ff;
   lccu_kind_type         sq_kind_ff;
   logic [COLOR_BITS-1:0] sq_color_ff;
   logic [SQ-1:0]         sq_ff [LIVE_PICKS][CHANNELS];
   logic [SQ-1:0]         sq_in [LIVE_PICKS][CHANNELS];

   // root pipeline, entry 0 holds the sums
   logic [CB:0]           pv_ff;
   lccu_kind_type         pk_ff [CB+1];
   lccu_kind_type         pk_in [CB+1];
   logic [COLOR_BITS-1:0] pc_ff [CB+1];
   logic [COLOR_BITS-1:0] pc_in [CB+1];
   logic [SW-1:0]         ps_ff [CB+1][CHANNELS];
   logic [SW-1:0]         ps_in [CB+1][CHANNELS];
   logic [CB-1:0]         pr_ff [CB+1][CHANNELS];
   logic [CB-1:0]         pr_in [CB+1][CHANNELS];
   logic [SW-1:0]         pt_ff [CB+1][CHANNELS];
   logic [SW-1:0]         pt_in [CB+1][CHANNELS];

   logic                  rsp_valid_ff;
   logic                  rsp_alive_ff;
   logic                  rsp_alive_in;
   logic [COLOR_BITS-1:0] rsp_color_ff;
   logic [COLOR_BITS-1:0] rsp_color_in;
   logic [CW-1:0]         mean_packed;
   logic [CW+COLOR_BITS-1:0] mean_wide;

   // the whole pipe moves together; hold everything while the output stalls
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign q_ready   = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_alive = rsp_alive_ff;
   assign rsp_color = rsp_color_ff;

   always_comb begin
      logic [CW+COLOR_BITS-1:0] ext_wide;
      logic [CW-1:0]            ext;
      logic [CB-1:0]            ch;
      for (int i = 0; i < LIVE_PICKS; i++) begin
         ext_wide = {{CW{1'b0}}, q_data.live[i]};
         ext      = ext_wide[CW-1:0];
         for (int c = 0; c < CHANNELS; c++) begin
            ch          = ext[c*CB +: CB];
            sq_in[i][c] = {{CB{1'b0}}, ch} * {{CB{1'b0}}, ch};
         end
      end
   end

   always_comb begin
      pk_in[0] = sq_kind_ff;
      pc_in[0] = sq_color_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         ps_in[0][c] = {2'b00, sq_ff[0][c]} + {2'b00, sq_ff[1][c]} + {2'b00, sq_ff[2][c]};
         pr_in[0][c] = '0;
         pt_in[0][c] = '0;
      end
   end

   for (genvar j = 1; j <= CB; j++) begin : g_root
      localparam int K = CB - j;
      logic [SW:0] dlt  [CHANNELS];
      logic [SW:0] cand [CHANNELS];

      // try root bit K: 3*(r + 2^K)^2 = tri + 3*(r*2^(K+1) + 4^K)
      always_comb begin
         pk_in[j] = pk_ff[j-1];
         pc_in[j] = pc_ff[j-1];
         for (int c = 0; c < CHANNELS; c++) begin
            dlt[c]  = ({{(SW+1-CB){1'b0}}, pr_ff[j-1][c]} << (K + 1)) | (STEP_ONE << (2 * K));
            cand[c] = {1'b0, pt_ff[j-1][c]} + dlt[c] + (dlt[c] << 1);
            ps_in[j][c] = ps_ff[j-1][c];
            if (cand[c] <= {1'b0, ps_ff[j-1][c]}) begin
               pr_in[j][c] = pr_ff[j-1][c] | (ROOT_ONE << K);
               pt_in[j][c] = cand[c][SW-1:0];
            end else begin
               pr_in[j][c] = pr_ff[j-1][c];
               pt_in[j][c] = pt_ff[j-1][c];
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         mean_packed[c*CB +: CB] = pr_ff[CB][c];
      end
      mean_wide    = {{COLOR_BITS{1'b0}}, mean_packed};
      rsp_alive_in = (pk_ff[CB] != KIND_DEAD);
      rsp_color_in = (pk_ff[CB] == KIND_MEAN) ? mean_wide[COLOR_BITS-1:0] : pc_ff[CB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff    <= 1'b0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_vld_ff    <= q_valid;
         pv_ff        <= {pv_ff[CB-1:0], sq_vld_ff};
         rsp_valid_ff <= pv_ff[CB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_kind_ff  <= q_data.kind;
         sq_color_ff <= q_data.color;
         sq_ff       <= sq_in;
         pk_ff       <= pk_in;
         pc_ff       <= pc_in;
         ps_ff       <= ps_in;
         pr_ff       <= pr_in;
         pt_ff       <= pt_in;
         rsp_alive_ff <= rsp_alive_in;
         rsp_color_ff <= rsp_color_in;
      end
   end

endmodule

// ----- rtl/core/life_cell_color_update.sv -----
// Colored B3/S23 life cell update.
// req_*: one cell per transfer (own alive bit, colors, eight neighbors, two draws).
// rsp_*: one result per accepted cell, in order: next alive bit and next color.
// csr_*: writes the 4-bit inherit threshold; always ready, reset value 8.
//   Write it only while no cell is in flight.
// A survivor keeps its color, a dead cell turns white. A birth copies the
// color of the live neighbor chosen by pick_draw when mode_draw is below the
// threshold, else each channel becomes the integer root mean square of the
// three live colors.
// Pipeline: queue, square stage, sum stage, one root stage per channel bit,
//   output register.
// Throughput: one cell per cycle unless stalled; the root pipeline takes a new cell per cycle.
// Stall: a held rsp_tready freezes the back pipeline; the four-entry queue
//   keeps taking cells until it fills, then req_tready drops.
// Reset clears the queue and all valid bits and sets the threshold to 8.
// Depends on lccu_pkg, lccu_front, lccu_queue, lccu_back.
module life_cell_color_update #(
   parameter int CHANNEL_BITS = lccu_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   // [8:0] alive_mask, [32:9] self_color, neighbor_color_i at [33+24i +: 24],
   // [228:225] mode_draw, [230:229] pick_draw, [231] zero
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [231:0]  req_tdata,
   // [0] next_alive, [24:1] next_color, [31:25] zero
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [3:0]    csr_data
);
   import lccu_pkg::*;

   lccu_item_type         item;
   lccu_entry_type        front_entry;
   lccu_entry_type        q_data;
   logic                  q_valid;
   logic                  q_ready;
   logic                  rsp_alive;
   logic [COLOR_BITS-1:0] rsp_color;

   always_comb begin
      item.alive_mask = req_tdata[8:0];
      item.self_color = req_tdata[32:9];
      for (int i = 0; i < NEIGHBORS; i++) begin
         item.neighbor_color[i] = req_tdata[33 + COLOR_BITS*i +: COLOR_BITS];
      end
      item.mode_draw  = req_tdata[228:225];
      item.pick_draw  = req_tdata[230:229];
   end

   lccu_front #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .item      (item),
      .entry     (front_entry)
   );

   lccu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (front_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   lccu_back #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_alive (rsp_alive),
      .rsp_color (rsp_color)
   );

   assign rsp_tdata = {7'b0000000, rsp_color, rsp_alive};

endmodule
